FILE: src/fsst_pkg.sv
// fsst_pkg: shared types and constants for the floor search sorted table unit.
// Used by fsst_front, fsst_back and the top level; no dependencies.
`default_nettype none

package fsst_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_W         = 32;

	localparam logic [1:0] ACT_APPEND  = 2'd0;
	localparam logic [1:0] ACT_QUERY   = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	typedef struct packed {
		logic [1:0]                 action;
		logic signed [VALUE_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic                       found;
		logic signed [VALUE_W-1:0] floor_value;
	} out_t;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'b001,
		OP_QUERY   = 3'b010,
		OP_RESTART = 3'b100
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0] value;
	} job_t;

endpackage

`default_nettype wire

FILE: src/fsst_ram.sv
// fsst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fsst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/fsst_front.sv
// fsst_front: accepts commands, classifies the action and queues jobs (2 deep).
// Depends on fsst_pkg.
`default_nettype none

module fsst_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output      logic           busy,
	input  wire fsst_pkg::in_t  cmd,
	output      logic           job_valid,
	output      fsst_pkg::job_t job,
	input  wire logic           pop
);

	import fsst_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       known;
	op_t        op;
	logic       push;

	always_comb begin
		known = 1'b1;
		op    = OP_APPEND;
		case (cmd.action)
			ACT_APPEND:  op = OP_APPEND;
			ACT_QUERY:   op = OP_QUERY;
			ACT_RESTART: op = OP_RESTART;
			default:     known = 1'b0;
		endcase
	end

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy && known;
	assign job_valid = (fill_q != 2'd0);
	assign job       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{op: op, value: cmd.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && job_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop && job_valid})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("queue fill out of range");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> job_valid)
		else $error("pop from empty queue");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !pop |=> busy)
		else $error("full queue drained without pop");

endmodule

`default_nettype wire

FILE: src/fsst_back.sv
// fsst_back: executes queued jobs; owns the entry count and the table RAM,
// runs the binary floor search one probe per cycle. Depends on fsst_pkg, fsst_ram.
`default_nettype none

module fsst_back #(
	parameter int TABLE_DEPTH = fsst_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire fsst_pkg::job_t job,
	output      logic           pop,
	output      logic           strobe,
	output      fsst_pkg::out_t result
);

	import fsst_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic signed [CW:0] ONE = (CW + 1)'(1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_PROBE = 2'b10
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	logic signed [CW:0]         lo_q;
	logic signed [CW:0]         hi_q;
	logic [AW-1:0]              mid_q;
	logic signed [VALUE_W-1:0] key_q;
	logic signed [VALUE_W-1:0] best_q;
	logic                       hit_q;
	logic                       strobe_q;
	out_t                       res_q;

	logic                       we;
	logic                       re;
	logic [VALUE_W-1:0]         rdata;
	logic signed [VALUE_W-1:0] entry;
	logic                       le;
	logic signed [CW:0]         mid_ext;
	logic signed [CW:0]         lo_n;
	logic signed [CW:0]         hi_n;
	logic signed [CW:0]         span;
	logic signed [CW:0]         mid_n;
	logic                       more;
	logic                       is_query;

	assign entry   = $signed(rdata);
	assign le      = (entry <= key_q);
	assign mid_ext = $signed({{(CW + 1 - AW){1'b0}}, mid_q});
	assign pop     = (state_q == ST_IDLE) && job_valid;
	assign is_query = pop && (job.op == OP_QUERY);
	assign we      = pop && (job.op == OP_APPEND) && (count_q < CW'(TABLE_DEPTH));

	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		case (state_q)
			ST_IDLE: begin
				lo_n = '0;
				hi_n = $signed({1'b0, count_q}) - ONE;
			end
			ST_PROBE: begin
				if (le) begin
					lo_n = mid_ext + ONE;
				end else begin
					hi_n = mid_ext - ONE;
				end
			end
			default: begin
				lo_n = lo_q;
				hi_n = hi_q;
			end
		endcase
		more  = (lo_n <= hi_n);
		span  = hi_n - lo_n;
		mid_n = lo_n + (span >>> 1);
		re    = more && (is_query || state_q == ST_PROBE);
	end

	fsst_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (job.value),
		.re    (re),
		.raddr (mid_n[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (re) begin
			mid_q <= mid_n[AW-1:0];
			lo_q  <= lo_n;
			hi_q  <= hi_n;
		end
		if (is_query) begin
			key_q  <= job.value;
			best_q <= '0;
		end else if (state_q == ST_PROBE && le) begin
			best_q <= entry;
		end
		if (is_query && !more) begin
			res_q <= '{found: 1'b0, floor_value: '0};
		end else if (state_q == ST_PROBE && !more) begin
			res_q <= '{found: le || hit_q, floor_value: le ? entry : best_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			hit_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (job.op)
							OP_APPEND: begin
								if (we) begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_RESTART: count_q <= '0;
							OP_QUERY: begin
								hit_q <= 1'b0;
								if (more) begin
									state_q <= ST_PROBE;
								end else begin
									strobe_q <= 1'b1;
								end
							end
							default: count_q <= count_q;
						endcase
					end
				end
				ST_PROBE: begin
					if (le) begin
						hit_q <= 1'b1;
					end
					if (!more) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above capacity");

	a_probe_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> (lo_q <= hi_q) && (mid_ext >= lo_q) && (mid_ext <= hi_q))
		else $error("probe outside search window");

	a_probe_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> hi_q < $signed({1'b0, count_q}))
		else $error("probe beyond filled entries");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !res_q.found |-> res_q.floor_value == '0)
		else $error("miss with nonzero value");

endmodule

`default_nettype wire

FILE: src/floor_search_sorted_table_unit.sv
// floor_search_sorted_table_unit: top level of the sorted-table floor search.
// Depends on fsst_pkg, fsst_front, fsst_back (and fsst_ram through fsst_back).
//
// Usage:
//   Command channel: cmd (action, value) is taken at a rising edge with start
//   high and busy low. Action 0 appends value as the next table entry (dropped
//   when the table holds TABLE_DEPTH entries), 1 queries the greatest entry not
//   above value, 2 empties the table, 3 is ignored.
//   Result channel: each query gives one transaction on result, valid for the
//   single cycle in which strobe is high. The receiver cannot stall it.
//   A two-deep command queue sits between the front and the execution unit;
//   busy is high while that queue is full.
// Execution:
//   Append and restart are executed as the job is popped. A query is issued
//   and then probes the table in a binary search (about log2 of the entry count,
//   at most log2(TABLE_DEPTH)+1 probes), strobe following the last probe. No new
//   job is taken while a query probes. The probe loop is bound by the single RAM
//   read port with registered read data.
// Reset: arst_n clears the queue, the entry count and the state machine; no
//   table clearing pass is needed since only filled entries are read.
`default_nettype none

module floor_search_sorted_table_unit #(
	parameter int TABLE_DEPTH = fsst_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output      logic          busy,
	input  wire fsst_pkg::in_t cmd,
	output      logic          strobe,
	output      fsst_pkg::out_t result
);

	import fsst_pkg::*;

	logic job_valid;
	job_t job;
	logic pop;

	fsst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.job_valid (job_valid),
		.job       (job),
		.pop       (pop)
	);

	fsst_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.pop       (pop),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

`default_nettype wire
